// ===== rtl/core/bdd_pkg.sv =====
// Shared constants, types and helper functions for the block dictionary decompressor.
// Every file under rtl/core but bdd_ifs depends on this package.
`timescale 1ns / 1ps
`default_nettype none

package bdd_pkg;

    localparam int unsigned DICT_ENTRIES  = 256;
    localparam int unsigned ENTRY_BYTES   = 8;
    localparam int unsigned MAX_OUT_BYTES = 16 * 1024;

    localparam int unsigned IDX_W   = $clog2(DICT_ENTRIES);
    localparam int unsigned ENTRY_W = 8 * ENTRY_BYTES;
    localparam int unsigned CNT_W   = $clog2(ENTRY_BYTES + 1);
    localparam int unsigned POS_W   = $clog2(ENTRY_BYTES);
    localparam int unsigned REM_W   = $clog2(MAX_OUT_BYTES);

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_TRUNC = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [5:0] {
        PH_CHECK   = 6'b000001,
        PH_SIZE    = 6'b000010,
        PH_INDEX   = 6'b000100,
        PH_MASK    = 6'b001000,
        PH_LIT     = 6'b010000,
        PH_DISCARD = 6'b100000
    } phase_t;

    // One window (or end marker) handed from the parser to the emitter.
    // count == 0 with last set is an empty end marker.
    typedef struct packed {
        logic [ENTRY_W-1:0] data;
        logic [CNT_W-1:0]   count;
        logic               last;
        logic [1:0]         status;
    } job_t;

    // Byte count of a window: min(req, ENTRY_BYTES, rem).
    function automatic logic [CNT_W-1:0] clip_count(input logic [7:0] req,
                                                    input logic [REM_W-1:0] rem);
        logic [CNT_W-1:0] c;
        if (req >= 8'(ENTRY_BYTES))
            c = CNT_W'(ENTRY_BYTES);
        else
            c = req[CNT_W-1:0];
        if (REM_W'(c) > rem)
            c = rem[CNT_W-1:0];
        return c;
    endfunction

    // Byte modulo DICT_ENTRIES; the entry count is a power of two, so the
    // wrap keeps the low index bits.
    function automatic logic [IDX_W-1:0] wrap_index(input logic [7:0] b);
        return b[IDX_W-1:0];
    endfunction

    // Position of the lowest set bit in a literal mask (0 if none).
    function automatic logic [POS_W-1:0] lowest_bit(input logic [ENTRY_BYTES-1:0] m);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = ENTRY_BYTES - 1; i >= 0; i--)
        begin
            if (m[i])
                p = POS_W'(i);
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bdd_ifs.sv =====
// Valid/ready stream interfaces for the compressed input and decompressed output.
// Depends on nothing but the language.
`timescale 1ns / 1ps
`default_nettype none

interface bdd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface bdd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_end;
    logic [1:0] out_status;

    modport source (output valid, output out_byte, output out_valid, output out_end,
                    output out_status, input ready);
    modport sink   (input valid, input out_byte, input out_valid, input out_end,
                    input out_status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bdd_front.sv =====
// Header/group parser and dictionary memory; produces window jobs for the emitter.
// Depends on bdd_pkg and bdd_in_if.
`timescale 1ns / 1ps
`default_nettype none

module bdd_front
    import bdd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    bdd_in_if.sink    comp,
    output logic      job_valid,
    output job_t      job,
    input  wire logic job_ready
);

    localparam logic [1:0] HDR_LAST = 2'd3;

    // dictionary storage: one row per entry, read data registered
    logic [ENTRY_W-1:0] dict_mem [DICT_ENTRIES];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [DICT_ENTRIES-1:0] dict_vld_reg;
    logic               ent_valid_reg;

    phase_t             phase_reg, phase_next;
    logic [1:0]         hc_reg, hc_next;
    logic [23:0]        size_reg, size_next;
    logic [REM_W-1:0]   remain_reg, remain_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [ENTRY_BYTES-1:0] mask_reg, mask_next;
    logic [ENTRY_W-1:0] work_reg, work_next;
    logic [ENTRY_W-1:0] win_reg, win_next;
    logic               pend_reg, pend_next;
    logic               job_valid_reg;
    job_t               job_reg, job_new;

    logic               accept;
    logic               job_set;
    logic               clear;
    logic               dict_we;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] entry_sel;
    logic [POS_W-1:0]   pos;
    logic [ENTRY_W-1:0] lit_data;
    logic [ENTRY_BYTES-1:0] mask_clr;
    logic [31:0]        full_size;
    logic [CNT_W-1:0]   cnt;

    // the job register frees up in the same cycle the emitter takes it
    assign comp.ready = !job_valid_reg || job_ready;
    assign accept     = comp.valid && comp.ready;
    assign job_valid  = job_valid_reg;
    assign job        = job_reg;

    // entries never written since the last clear read as their reset pattern
    assign entry_sel = ent_valid_reg ? rd_data_reg : {ENTRY_BYTES{8'(idx_reg)}};
    assign pos       = lowest_bit(mask_reg);
    assign mask_clr  = mask_reg & ~(ENTRY_BYTES'(1) << pos);
    assign full_size = {comp.in_byte, size_reg};
    assign rd_addr   = wrap_index(comp.in_byte);

    always_comb
    begin
        lit_data = work_reg;
        lit_data[8*pos +: 8] = comp.in_byte;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        hc_next     = hc_reg;
        size_next   = size_reg;
        remain_next = remain_reg;
        idx_next    = idx_reg;
        mask_next   = mask_reg;
        work_next   = work_reg;
        win_next    = win_reg;
        pend_next   = pend_reg;
        job_set     = 1'b0;
        job_new     = '{data: '0, count: '0, last: 1'b1, status: STATUS_OK};
        clear       = 1'b0;
        dict_we     = 1'b0;
        rd_en       = 1'b0;
        cnt         = '0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_CHECK:
                begin
                    if (comp.in_last)
                    begin
                        job_set = 1'b1;
                        job_new.status = STATUS_TRUNC;
                        clear = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_SIZE;
                        hc_next    = '0;
                        size_next  = '0;
                    end
                end
                PH_SIZE:
                begin
                    if (hc_reg != HDR_LAST)
                    begin
                        size_next[8*hc_reg +: 8] = comp.in_byte;
                        hc_next = hc_reg + 2'd1;
                        if (comp.in_last)
                        begin
                            job_set = 1'b1;
                            job_new.status = STATUS_TRUNC;
                            clear = 1'b1;
                        end
                    end
                    else
                    begin
                        hc_next = '0;
                        if (full_size == 32'd0 || full_size >= 32'(MAX_OUT_BYTES))
                        begin
                            job_set = 1'b1;
                            job_new.status = STATUS_RANGE;
                            if (comp.in_last)
                                clear = 1'b1;
                            else
                                phase_next = PH_DISCARD;
                        end
                        else
                        begin
                            remain_next = full_size[REM_W-1:0];
                            phase_next  = PH_INDEX;
                            if (comp.in_last)
                            begin
                                job_set = 1'b1;
                                clear = 1'b1;
                            end
                        end
                    end
                end
                PH_INDEX:
                begin
                    if (comp.in_last)
                    begin
                        job_set = 1'b1;
                        clear   = 1'b1;
                        if (!pend_reg)
                            job_new.status = STATUS_TRUNC;
                        else
                        begin
                            // lone trailing byte cuts the last window
                            job_new.data  = win_reg;
                            job_new.count = clip_count(comp.in_byte, remain_reg);
                        end
                    end
                    else
                    begin
                        if (pend_reg)
                        begin
                            cnt         = clip_count(8'(ENTRY_BYTES), remain_reg);
                            remain_next = remain_reg - REM_W'(cnt);
                            pend_next   = 1'b0;
                            if (cnt != '0)
                            begin
                                job_set = 1'b1;
                                job_new = '{data: win_reg, count: cnt, last: 1'b0,
                                            status: STATUS_OK};
                            end
                        end
                        idx_next   = rd_addr;
                        rd_en      = 1'b1;
                        phase_next = PH_MASK;
                    end
                end
                PH_MASK:
                begin
                    if (comp.in_byte == 8'd0)
                    begin
                        win_next   = entry_sel;
                        pend_next  = 1'b1;
                        phase_next = PH_INDEX;
                        if (comp.in_last)
                        begin
                            job_set = 1'b1;
                            job_new.data  = entry_sel;
                            job_new.count = clip_count(8'(ENTRY_BYTES), remain_reg);
                            clear = 1'b1;
                        end
                    end
                    else if (comp.in_last)
                    begin
                        job_set = 1'b1;
                        job_new.status = STATUS_TRUNC;
                        clear = 1'b1;
                    end
                    else
                    begin
                        work_next  = entry_sel;
                        mask_next  = comp.in_byte;
                        phase_next = PH_LIT;
                    end
                end
                PH_LIT:
                begin
                    mask_next = mask_clr;
                    work_next = lit_data;
                    if (mask_clr == '0)
                    begin
                        win_next   = lit_data;
                        pend_next  = 1'b1;
                        phase_next = PH_INDEX;
                        if (comp.in_last)
                        begin
                            job_set = 1'b1;
                            job_new.data  = lit_data;
                            job_new.count = clip_count(8'(ENTRY_BYTES), remain_reg);
                            clear = 1'b1;
                        end
                        else
                            dict_we = 1'b1;
                    end
                    else if (comp.in_last)
                    begin
                        job_set = 1'b1;
                        job_new.status = STATUS_TRUNC;
                        clear = 1'b1;
                    end
                end
                PH_DISCARD:
                begin
                    if (comp.in_last)
                        clear = 1'b1;
                end
                default:
                begin
                    clear = 1'b1;
                end
            endcase
        end

        // end of stream: the parser state and the dictionary row flags go back to their reset values
        if (clear)
        begin
            phase_next  = PH_CHECK;
            hc_next     = '0;
            size_next   = '0;
            remain_next = '0;
            idx_next    = '0;
            mask_next   = '0;
            pend_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CHECK;
            hc_reg        <= '0;
            size_reg      <= '0;
            remain_reg    <= '0;
            idx_reg       <= '0;
            mask_reg      <= '0;
            pend_reg      <= 1'b0;
            dict_vld_reg  <= '0;
            ent_valid_reg <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hc_reg     <= hc_next;
            size_reg   <= size_next;
            remain_reg <= remain_next;
            idx_reg    <= idx_next;
            mask_reg   <= mask_next;
            pend_reg   <= pend_next;
            if (clear)
                dict_vld_reg <= '0;
            else if (dict_we)
                dict_vld_reg[idx_reg] <= 1'b1;
            if (rd_en)
                ent_valid_reg <= dict_vld_reg[rd_addr];
            if (job_set)
                job_valid_reg <= 1'b1;
            else if (job_ready)
                job_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        win_reg  <= win_next;
        if (job_set)
            job_reg <= job_new;
    end

    // write-back and read never fall on the same beat: a group needs at least two
    always_ff @(posedge clk)
    begin
        if (dict_we)
            dict_mem[idx_reg] <= lit_data;
        if (rd_en)
            rd_data_reg <= dict_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/bdd_emit.sv =====
// Window emitter: shifts one job out a byte per cycle into the output register while decomp is ready.
// Depends on bdd_pkg and bdd_out_if.
`timescale 1ns / 1ps
`default_nettype none

module bdd_emit
    import bdd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  job_valid,
    input  wire job_t  job,
    output logic       job_ready,
    bdd_out_if.source  decomp
);

    logic [ENTRY_W-1:0] sh_data_reg, sh_data_next;
    logic [CNT_W-1:0]   sh_left_reg, sh_left_next;
    logic               sh_mark_reg, sh_mark_next;
    logic               sh_last_reg, sh_last_next;
    logic [1:0]         sh_status_reg, sh_status_next;

    logic               ob_valid_reg, ob_valid_next;
    logic [7:0]         ob_byte_reg, ob_byte_next;
    logic               ob_data_reg, ob_data_next;
    logic               ob_end_reg, ob_end_next;
    logic [1:0]         ob_status_reg, ob_status_next;

    logic sh_busy;
    logic advance;
    logic take;

    assign sh_busy   = (sh_left_reg != '0) || sh_mark_reg;
    assign advance   = sh_busy && (!ob_valid_reg || decomp.ready);
    // busy with nothing left to shift means an end marker is pending
    assign job_ready = !sh_busy || (advance && sh_left_reg <= CNT_W'(1));
    assign take      = job_valid && job_ready;

    assign decomp.valid      = ob_valid_reg;
    assign decomp.out_byte   = ob_byte_reg;
    assign decomp.out_valid  = ob_data_reg;
    assign decomp.out_end    = ob_end_reg;
    assign decomp.out_status = ob_status_reg;

    always_comb
    begin
        sh_data_next   = sh_data_reg;
        sh_left_next   = sh_left_reg;
        sh_mark_next   = sh_mark_reg;
        sh_last_next   = sh_last_reg;
        sh_status_next = sh_status_reg;
        ob_valid_next  = ob_valid_reg;
        ob_byte_next   = ob_byte_reg;
        ob_data_next   = ob_data_reg;
        ob_end_next    = ob_end_reg;
        ob_status_next = ob_status_reg;

        if (advance)
        begin
            ob_valid_next = 1'b1;
            if (sh_left_reg != '0)
            begin
                ob_byte_next   = sh_data_reg[7:0];
                ob_data_next   = 1'b1;
                ob_end_next    = sh_last_reg && (sh_left_reg == CNT_W'(1));
                ob_status_next = STATUS_OK;
                sh_data_next   = sh_data_reg >> 8;
                sh_left_next   = sh_left_reg - CNT_W'(1);
            end
            else
            begin
                ob_byte_next   = 8'd0;
                ob_data_next   = 1'b0;
                ob_end_next    = 1'b1;
                ob_status_next = sh_status_reg;
                sh_mark_next   = 1'b0;
            end
        end
        else if (decomp.ready)
            ob_valid_next = 1'b0;

        if (take)
        begin
            sh_data_next   = job.data;
            sh_left_next   = job.count;
            sh_mark_next   = (job.count == '0);
            sh_last_next   = job.last;
            sh_status_next = job.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_left_reg  <= '0;
            sh_mark_reg  <= 1'b0;
            ob_valid_reg <= 1'b0;
        end
        else
        begin
            sh_left_reg  <= sh_left_next;
            sh_mark_reg  <= sh_mark_next;
            ob_valid_reg <= ob_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_data_reg   <= sh_data_next;
        sh_last_reg   <= sh_last_next;
        sh_status_reg <= sh_status_next;
        ob_byte_reg   <= ob_byte_next;
        ob_data_reg   <= ob_data_next;
        ob_end_reg    <= ob_end_next;
        ob_status_reg <= ob_status_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/block_dictionary_decompressor.sv =====
// Top level of the block dictionary decompressor.
// Depends on bdd_pkg, bdd_ifs, bdd_front and bdd_emit.
//
// comp carries the compressed stream, one byte per beat, in_last on the final
// byte. decomp returns decompressed bytes one per beat; out_valid = 0 marks an
// empty end marker, out_end flags the last beat of a stream and out_status
// reports a truncated stream (1) or a declared size out of range (2).
// The parser reads a dictionary row on each index byte and writes it back
// when the group's literals are done; a window is queued as one job.
// A window passes through the job register, the emitter's shift register and
// the output register on its way to decomp. Output runs at one byte per
// cycle while decomp is ready, and comp accepts a byte every cycle except
// while a queued window waits behind the one being emitted.
// Reset, like the end of every stream, clears all dictionary row flags at
// once, so rows read back as their reset pattern; no clearing pass is needed.
// When decomp stalls, the output register holds and comp stalls as soon as
// the next window has nowhere to go.
`timescale 1ns / 1ps
`default_nettype none

module block_dictionary_decompressor
    import bdd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    bdd_in_if.sink    comp,
    bdd_out_if.source decomp
);

    logic job_valid;
    logic job_ready;
    job_t job;

    bdd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .comp      (comp),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready)
    );

    bdd_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready),
        .decomp    (decomp)
    );

    a_job_hold: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && !job_ready |=> job_valid && $stable(job))
        else $error("window job changed while waiting for the emitter");

    a_job_count: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> job.count <= CNT_W'(ENTRY_BYTES))
        else $error("window job longer than one entry");

    a_data_status: assert property (@(posedge clk) disable iff (!rst_n)
        decomp.valid && decomp.out_valid |-> decomp.out_status == STATUS_OK)
        else $error("data beat carries an error status");

    a_marker_end: assert property (@(posedge clk) disable iff (!rst_n)
        decomp.valid && !decomp.out_valid |-> decomp.out_end)
        else $error("empty marker without end flag");

endmodule

`default_nettype wire
